@@ design/frbc_pkg.sv @@
// Package for the framed byte receiver with additive checksum.
// Holds the parser phase type, the result item struct and the frame constants.
// No dependencies.
`timescale 1ns / 1ps

package frbc_pkg;

  // Width of the ring address and tail fields on the output stream.
  localparam int unsigned ADDR_W = 10;

  // Header bytes of a frame: 'Z' then 'Y'.
  localparam logic [7:0] FLAG1_BYTE = 8'h5A;
  localparam logic [7:0] FLAG2_BYTE = 8'h59;

  // Number of result queue entries.
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    PH_FLAG1 = 3'd0,
    PH_FLAG2 = 3'd1,
    PH_LEN1  = 3'd2,
    PH_LEN2  = 3'd3,
    PH_TYPE  = 3'd4,
    PH_ID    = 3'd5,
    PH_DATA  = 3'd6,
    PH_CHECK = 3'd7
  } phase_e;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    logic              done;
    logic [ADDR_W-1:0] tail;
    logic              last;
  } result_t;

  // Up to two results produced by one byte.
  typedef struct packed {
    logic [1:0] num;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

@@ design/frbc_parser.sv @@
// Frame parser: phase register, running sum, length, count and ring tail.
// Turns one byte combinationally into zero, one or two ring write results.
// Depends on frbc_pkg.
`timescale 1ns / 1ps

module frbc_parser import frbc_pkg::*; #(
  parameter int unsigned RING_SIZE = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] byte_i,
  output push_t      push_o
);

  localparam int unsigned TW = $clog2(RING_SIZE);
  localparam int unsigned EW = (TW > ADDR_W) ? TW : ADDR_W;
  localparam logic [TW:0] RING_W = (TW + 1)'(RING_SIZE);

  phase_e        phase_q, phase_d;
  logic [7:0]    sum_q, sum_d;
  logic [15:0]   len_q, len_d;
  logic [15:0]   cnt_q, cnt_d;
  logic [TW-1:0] tail_q, tail_d;
  // Ring slot of tail + count, kept modulo the ring size.
  logic [TW-1:0] slot_q, slot_d;

  logic [TW-1:0] slot_inc1;
  logic [TW-1:0] tail_inc1;
  logic [TW-1:0] tail_inc2;
  logic          take_data;

  function automatic logic [TW-1:0] ring_add(input logic [TW-1:0] v, input logic [1:0] inc);
    logic [TW:0] s;
    s = {1'b0, v} + (TW + 1)'(inc);
    if (s >= RING_W) begin
      s = s - RING_W;
    end
    return s[TW-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] to_addr(input logic [TW-1:0] v);
    logic [EW-1:0] e;
    e = EW'(v);
    return e[ADDR_W-1:0];
  endfunction

  assign slot_inc1 = ring_add(slot_q, 2'd1);
  assign tail_inc1 = ring_add(tail_q, 2'd1);
  assign tail_inc2 = ring_add(tail_q, 2'd2);
  // Signed test count < length - 3, done without a sign as count + 3 < length.
  assign take_data = (({1'b0, cnt_q} + 17'd3) < {1'b0, len_q});

  always_comb begin
    phase_d = phase_q;
    sum_d   = sum_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    tail_d  = tail_q;
    slot_d  = slot_q;
    push_o  = '0;
    push_o.r0.tail = to_addr(tail_q);
    push_o.r1.tail = to_addr(tail_q);

    case (phase_q)
      PH_FLAG1: begin
        if (byte_i == FLAG1_BYTE) begin
          phase_d = PH_FLAG2;
          sum_d   = sum_q + byte_i;
        end
      end
      PH_FLAG2: begin
        if (byte_i == FLAG2_BYTE) begin
          phase_d = PH_LEN1;
          sum_d   = sum_q + byte_i;
        end else begin
          // Drop the frame and look at this byte again as a first header byte.
          cnt_d   = '0;
          slot_d  = tail_q;
          phase_d = (byte_i == FLAG1_BYTE) ? PH_FLAG2 : PH_FLAG1;
          sum_d   = (byte_i == FLAG1_BYTE) ? byte_i : 8'd0;
        end
      end
      PH_LEN1: begin
        phase_d = PH_LEN2;
        cnt_d   = cnt_q + 16'd2;
        slot_d  = ring_add(slot_q, 2'd2);
        len_d   = {byte_i, 8'h00};
        sum_d   = sum_q + byte_i;
      end
      PH_LEN2: begin
        phase_d = PH_TYPE;
        len_d   = len_q | {8'h00, byte_i};
        sum_d   = sum_q + byte_i;
      end
      default: begin
        if (phase_q inside {PH_TYPE, PH_ID} ||
            (phase_q == PH_DATA && take_data)) begin
          // Stored byte: type, id or data.
          if (phase_q == PH_TYPE) begin
            phase_d = PH_ID;
          end else begin
            phase_d = PH_DATA;
          end
          cnt_d          = cnt_q + 16'd1;
          slot_d         = slot_inc1;
          sum_d          = sum_q + byte_i;
          push_o.num     = 2'd1;
          push_o.r0.addr = to_addr(slot_inc1);
          push_o.r0.data = byte_i;
          push_o.r0.last = 1'b1;
        end else if (byte_i == sum_q) begin
          // Good checksum: write the count big-endian behind the tail and advance.
          phase_d        = PH_FLAG1;
          sum_d          = '0;
          cnt_d          = '0;
          len_d          = '0;
          tail_d         = slot_q;
          push_o.num     = 2'd2;
          push_o.r0.addr = to_addr(tail_inc1);
          push_o.r0.data = cnt_q[15:8];
          push_o.r1.addr = to_addr(tail_inc2);
          push_o.r1.data = cnt_q[7:0];
          push_o.r1.done = 1'b1;
          push_o.r1.tail = to_addr(slot_q);
          push_o.r1.last = 1'b1;
        end else begin
          // Bad checksum: drop the frame, the byte may start a new one.
          cnt_d   = '0;
          slot_d  = tail_q;
          phase_d = (byte_i == FLAG1_BYTE) ? PH_FLAG2 : PH_FLAG1;
          sum_d   = (byte_i == FLAG1_BYTE) ? byte_i : 8'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FLAG1;
      sum_q   <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      tail_q  <= '0;
      slot_q  <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      tail_q  <= tail_d;
      slot_q  <= slot_d;
    end
  end

endmodule

@@ design/frbc_out_queue.sv @@
// Result queue: takes up to two results per cycle, hands out one per cycle while ready_i is high.
// Register array with read and write pointers.
// Depends on frbc_pkg.
`timescale 1ns / 1ps

module frbc_out_queue import frbc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_en_i,
  input  push_t   push_i,
  output logic    room_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t res_o
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  result_t         mem_q [QUEUE_DEPTH];
  logic [PW-1:0]   wptr_q, wptr_d;
  logic [PW-1:0]   rptr_q, rptr_d;
  logic [PW:0]     cnt_q, cnt_d;
  logic [1:0]      num;
  logic            pop;
  logic [PW-1:0]   wptr_nx;

  assign num     = push_en_i ? push_i.num : 2'd0;
  assign pop     = valid_o && ready_i;
  assign wptr_nx = wptr_q + PW'(1);
  assign valid_o = (cnt_q != '0);
  assign res_o   = mem_q[rptr_q];
  // Room for a full pair of results.
  assign room_o  = (cnt_q <= (PW + 1)'(QUEUE_DEPTH - 2));

  always_comb begin
    wptr_d = wptr_q + PW'(num);
    rptr_d = pop ? rptr_q + PW'(1) : rptr_q;
    cnt_d  = cnt_q + (PW + 1)'(num) - (PW + 1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (num != 2'd0) begin
      mem_q[wptr_q] <= push_i.r0;
    end
    if (num == 2'd2) begin
      mem_q[wptr_nx] <= push_i.r1;
    end
  end

endmodule

@@ design/framed_byte_receiver_checksum.sv @@
// Framed byte receiver with 8-bit additive checksum. Bytes arrive on the input
// stream one item each and are parsed as frames: 'Z', 'Y', a big-endian 16-bit
// length, a type byte, an id byte, data bytes and a checksum byte equal to the
// 8-bit sum of all bytes before it. Type, id and data bytes each give one ring
// write item at tail + count; a good checksum gives two items that write the
// count big-endian at tail + 1 and tail + 2, the second one flagged in tuser
// and carrying the advanced tail. A bad header or checksum byte drops the frame
// and is looked at again as a possible start of the next one; such bytes and
// header bytes give no items. The input byte is registered and parsed, and its
// results go into a four-entry queue; a byte is taken every cycle while the
// queue holds at most two results, and its first item reaches the receiver
// through the input register and the queue. The output side drains one item
// per cycle while the receiver is ready. A frame with n stored bytes is n + 5
// input items and gives n + 2 output items, so with a ready receiver the input
// never stalls and one byte is taken every cycle; a stalled receiver stops the
// input once the queue holds three results and one byte waits in the register.
// Depends on frbc_pkg, frbc_parser and frbc_out_queue.
`timescale 1ns / 1ps

module framed_byte_receiver_checksum import frbc_pkg::*; #(
  parameter int unsigned RING_SIZE = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [9:0] write_address, [17:10] write_data,
                                        // [27:18] new_tail, [31:28] zero
  output logic        m_axis_tuser_o,   // [0] frame_done
  output logic        m_axis_tlast_o    // final item caused by one byte
);

  // Input register holding one accepted byte.
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  logic       room;
  logic       proc_fire;
  push_t      push;
  result_t    res;

  // A held byte is parsed as soon as the queue can take both of its results.
  assign proc_fire       = in_valid_q && room;
  assign s_axis_tready_o = !in_valid_q || proc_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  frbc_parser #(
    .RING_SIZE(RING_SIZE)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (proc_fire),
    .byte_i (in_byte_q),
    .push_o (push)
  );

  frbc_out_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_en_i (proc_fire),
    .push_i    (push),
    .room_o    (room),
    .valid_o   (m_axis_tvalid_o),
    .ready_i   (m_axis_tready_i),
    .res_o     (res)
  );

  assign m_axis_tdata_o = {4'b0000, res.tail, res.data, res.addr};
  assign m_axis_tuser_o = res.done;
  assign m_axis_tlast_o = res.last;

endmodule

@@ sim/tb_framed_byte_receiver_checksum.sv @@
// Self-checking testbench for framed_byte_receiver_checksum: drives received bytes on the
// input stream and checks every ring write item against a frame parser model or typed-in writes.
// Depends on frbc_pkg and the framed_byte_receiver_checksum RTL.
`timescale 1ns / 1ps

module tb_framed_byte_receiver_checksum;
  import frbc_pkg::*;

  localparam int RING = 1024;
  localparam int IDLE_LIMIT = 5000;    // cycles with no handshake on either side
  localparam int RANDOM_ITEMS = 900;   // parsed bytes before the random part stops
  localparam int HOLD_CYCLES = 400;    // the one long output hold-off
  localparam int DRAIN_CYCLES = 20;    // settle time after the last write item

  typedef struct {
    logic [7:0] b;
    bit         typed;
    int         n;
    result_t    w0;
    result_t    w1;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_valid;
  logic [7:0]  s_data;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic        m_ready;
  logic [31:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        m_axis_tlast_o;

  // Frame parser model state.
  phase_e      prs_phase;
  logic [7:0]  prs_sum;
  logic [15:0] prs_len;
  logic [15:0] prs_count;
  logic [9:0]  prs_tail;

  result_t     byte_writes[$];      // writes caused by the byte being parsed
  result_t     expected_writes[$];  // writes still owed by the block
  dir_row_t    dir_rows[$];
  int          errors = 0;
  int          parsed_items = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  framed_byte_receiver_checksum u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  function automatic result_t wr(int addr, logic [7:0] data, bit done, int tail, bit last);
    result_t w;
    w.addr = addr[9:0];
    w.data = data;
    w.done = done;
    w.tail = tail[9:0];
    w.last = last;
    return w;
  endfunction

  function automatic logic [9:0] ring_slot(int offset);
    return 10'((int'(prs_tail) + offset) % RING);
  endfunction

  function automatic void add_row(logic [7:0] b, bit typed, int n, result_t w0, result_t w1);
    dir_row_t r;
    r.b = b;
    r.typed = typed;
    r.n = n;
    r.w0 = w0;
    r.w1 = w1;
    dir_rows.push_back(r);
  endfunction

  // Type, id and data bytes bump the count first, then land at tail + count.
  task automatic store_ring_byte(input logic [7:0] b);
    prs_count = prs_count + 16'd1;
    byte_writes.push_back(wr(int'(ring_slot(int'(prs_count))), b, 1'b0, int'(prs_tail),
                             1'b0));
    prs_sum = prs_sum + b;
  endtask

  // Parses one byte and leaves the ring writes it causes in byte_writes.
  task automatic parse_byte(input logic [7:0] b);
    bit      again;
    result_t w;
    byte_writes.delete();
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (prs_phase)
        PH_FLAG1: begin
          if (b == FLAG1_BYTE) begin
            prs_phase = PH_FLAG2;
            prs_sum = prs_sum + b;
          end
        end
        PH_FLAG2: begin
          if (b == FLAG2_BYTE) begin
            prs_phase = PH_LEN1;
            prs_sum = prs_sum + b;
          end else begin
            // A bad second header byte may itself start the next frame.
            prs_phase = PH_FLAG1;
            prs_count = '0;
            prs_sum = '0;
            again = 1'b1;
          end
        end
        PH_LEN1: begin
          prs_count = prs_count + 16'd2;
          prs_phase = PH_LEN2;
          prs_len = {b, 8'h00};
          prs_sum = prs_sum + b;
        end
        PH_LEN2: begin
          prs_phase = PH_TYPE;
          prs_len = prs_len | {8'h00, b};
          prs_sum = prs_sum + b;
        end
        PH_TYPE: begin
          prs_phase = PH_ID;
          store_ring_byte(b);
        end
        PH_ID: begin
          prs_phase = PH_DATA;
          store_ring_byte(b);
        end
        default: begin
          if (prs_phase == PH_DATA && int'(prs_count) < int'(prs_len) - 3) begin
            store_ring_byte(b);
          end else begin
            prs_phase = PH_FLAG1;
            if (b == prs_sum) begin
              // Count goes big-endian to tail+1 and tail+2; the tail moves in between.
              byte_writes.push_back(wr(int'(ring_slot(1)), prs_count[15:8], 1'b0,
                                       int'(prs_tail), 1'b0));
              prs_tail = ring_slot(int'(prs_count));
              byte_writes.push_back(wr(int'(ring_slot(RING - int'(prs_count) % RING + 2)),
                                       prs_count[7:0], 1'b1, int'(prs_tail), 1'b0));
              prs_sum = '0;
              prs_count = '0;
              prs_len = '0;
            end else begin
              // A bad checksum byte is looked at again as a possible 'Z'.
              prs_sum = '0;
              prs_count = '0;
              again = 1'b1;
            end
          end
        end
      endcase
    end
    if (byte_writes.size() > 0) begin
      w = byte_writes.pop_back();
      w.last = 1'b1;
      byte_writes.push_back(w);
    end
  endtask

  // Offers one byte in the sender's burst pattern and waits for it to be taken.
  // Expected writes come from the parser unless the caller supplies its own.
  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input int n = 0, input result_t w0 = '0, input result_t w1 = '0);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    s_valid <= 1'b1;
    s_data <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    burst_left--;
    if (!(prs_phase == PH_FLAG1 && b != FLAG1_BYTE)) parsed_items++;
    parse_byte(b);
    if (typed) begin
      if (n > 0) expected_writes.push_back(w0);
      if (n > 1) expected_writes.push_back(w1);
    end else begin
      foreach (byte_writes[i]) expected_writes.push_back(byte_writes[i]);
    end
  endtask

  // Sends a frame whose data length follows the parser, so the checksum lands
  // where the block expects it. A bad checksum is any other byte.
  task automatic send_frame(input int len, input bit good_sum);
    int guard;
    logic [7:0] bad;
    send_byte(FLAG1_BYTE);
    send_byte(FLAG2_BYTE);
    send_byte(8'(len >> 8));
    send_byte(8'(len));
    send_byte(8'($urandom));
    send_byte(8'($urandom));
    guard = 0;
    while (prs_phase == PH_DATA && int'(prs_count) < int'(prs_len) - 3 && guard < 400) begin
      send_byte(8'($urandom));
      guard++;
    end
    if (good_sum) begin
      send_byte(prs_sum);
    end else begin
      bad = 8'($urandom_range(1, 255));
      send_byte(($urandom_range(0, 3) == 0 && prs_sum != FLAG1_BYTE) ?
                FLAG1_BYTE : prs_sum ^ bad);
    end
  endtask

  // Write items from the block, checked in order against the expectations.
  always @(posedge clk_i) begin : check_writes
    result_t seen;
    result_t want;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      seen = wr(int'(m_axis_tdata_o[9:0]), m_axis_tdata_o[17:10], m_axis_tuser_o,
                int'(m_axis_tdata_o[27:18]), m_axis_tlast_o);
      if (expected_writes.size() == 0) begin
        $display("%0t: unexpected write item addr=%0d data=%02h done=%0b tail=%0d last=%0b",
                 $time, seen.addr, seen.data, seen.done, seen.tail, seen.last);
        errors++;
      end else begin
        want = expected_writes.pop_front();
        if (seen.addr != want.addr || seen.data != want.data || seen.done != want.done ||
            seen.tail != want.tail || seen.last != want.last) begin
          $display("%0t: write mismatch: expected addr=%0d data=%02h done=%0b tail=%0d last=%0b",
                   $time, want.addr, want.data, want.done, want.tail, want.last);
          $display("%0t:                 actual addr=%0d data=%02h done=%0b tail=%0d last=%0b",
                   $time, seen.addr, seen.data, seen.done, seen.tail, seen.last);
          errors++;
        end
      end
    end
  end

  // Watchdog: any handshake on either side resets the idle count.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d writes outstanding",
                 $time, IDLE_LIMIT, expected_writes.size());
        $display("tb_framed_byte_receiver_checksum: done, errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Receiver: stretches of always-ready, mostly-ready, random and sparse acceptance, plus
  // one long hold-off mid-run so the block's queue fills and it stalls its input.
  initial begin : drive_ready
    int mode;
    int len;
    int rx_cycles;
    bit held;
    rx_cycles = 0;
    held = 1'b0;
    m_ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!held && rx_cycles >= 600) begin
        held = 1'b1;
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      mode = $urandom_range(0, 3);
      len = $urandom_range(8, 60);
      repeat (len) begin
        case (mode)
          0: m_ready <= 1'b1;
          1: m_ready <= 1'($urandom_range(0, 1));
          2: m_ready <= ($urandom_range(0, 3) == 0);
          default: m_ready <= (rx_cycles % 5 != 0);
        endcase
        rx_cycles++;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    int kind;
    int len;
    int n;
    // Directed frames from reset. Writes are typed in where they are obvious:
    // the first frame, the dropped bytes and the closing good checksum.
    add_row(8'h00, 1'b1, 0, '0, '0);                  // noise before any header
    add_row(8'hFF, 1'b1, 0, '0, '0);
    add_row(FLAG1_BYTE, 1'b1, 0, '0, '0);
    add_row(FLAG2_BYTE, 1'b1, 0, '0, '0);
    add_row(8'h00, 1'b1, 0, '0, '0);                  // length 8: one data byte
    add_row(8'h08, 1'b1, 0, '0, '0);
    add_row(8'h00, 1'b1, 1, wr(3, 8'h00, 1'b0, 0, 1'b1), '0);
    add_row(8'hFF, 1'b1, 1, wr(4, 8'hFF, 1'b0, 0, 1'b1), '0);
    add_row(8'h80, 1'b1, 1, wr(5, 8'h80, 1'b0, 0, 1'b1), '0);
    add_row(8'h3A, 1'b1, 2, wr(1, 8'h00, 1'b0, 0, 1'b0), wr(2, 8'h05, 1'b1, 5, 1'b1));
    add_row(FLAG1_BYTE, 1'b1, 0, '0, '0);
    add_row(FLAG1_BYTE, 1'b1, 0, '0, '0);             // bad second header, restarts
    add_row(FLAG2_BYTE, 1'b0, 0, '0, '0);
    add_row(8'h00, 1'b0, 0, '0, '0);                  // length 2, below three
    add_row(8'h02, 1'b0, 0, '0, '0);
    add_row(8'h11, 1'b0, 0, '0, '0);
    add_row(8'h22, 1'b0, 0, '0, '0);
    add_row(FLAG1_BYTE, 1'b1, 0, '0, '0);             // bad checksum, taken as 'Z'
    add_row(FLAG2_BYTE, 1'b0, 0, '0, '0);
    add_row(8'h00, 1'b0, 0, '0, '0);                  // length 0
    add_row(8'h00, 1'b0, 0, '0, '0);
    add_row(8'hA5, 1'b0, 0, '0, '0);
    add_row(FLAG1_BYTE, 1'b0, 0, '0, '0);
    add_row(8'hB2, 1'b1, 2, wr(6, 8'h00, 1'b0, 5, 1'b0), wr(7, 8'h04, 1'b1, 9, 1'b1));

    prs_phase = PH_FLAG1;
    prs_sum = '0;
    prs_len = '0;
    prs_count = '0;
    prs_tail = '0;
    rst_ni <= 1'b0;
    s_valid <= 1'b0;
    s_data <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].n, dir_rows[i].w0,
                dir_rows[i].w1);
    end

    // Random part: mostly well-formed frames with random content, the rest
    // broken headers, bad checksums, cut-off frames and plain noise.
    parsed_items = 0;
    while (parsed_items < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      len = ($urandom_range(0, 99) < 2) ? $urandom_range(256, 290) : $urandom_range(0, 24);
      if (kind < 70) begin
        send_frame(len, 1'b1);
      end else if (kind < 80) begin
        send_frame(len, 1'b0);
      end else if (kind < 88) begin
        send_byte(FLAG1_BYTE);
        send_byte(($urandom_range(0, 2) == 0) ? FLAG1_BYTE : 8'($urandom_range(0, 88)));
      end else if (kind < 94) begin
        send_byte(FLAG1_BYTE);
        send_byte(FLAG2_BYTE);
        send_byte(8'h00);
        send_byte(8'($urandom_range(0, 24)));
        n = $urandom_range(0, 5);
        repeat (n) send_byte(8'($urandom));
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) send_byte(8'($urandom));
      end
    end
    s_valid <= 1'b0;

    while (expected_writes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("tb_framed_byte_receiver_checksum: done, clean");
    end else begin
      $display("tb_framed_byte_receiver_checksum: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/frbc_pkg.sv
design/frbc_parser.sv
design/frbc_out_queue.sv
design/framed_byte_receiver_checksum.sv
sim/tb_framed_byte_receiver_checksum.sv
